>>> rtl/dwpw_pkg.sv
package dwpw_pkg;

  localparam logic [15:0] PanelWidth  = 16'd240;
  localparam logic [15:0] PanelHeight = 16'd320;

  localparam logic [15:0] ColEndReset = PanelWidth - 16'd1;
  localparam logic [15:0] RowEndReset = PanelHeight - 16'd1;

  localparam logic [7:0] CmdColumnAddr  = 8'h2A;
  localparam logic [7:0] CmdPageAddr    = 8'h2B;
  localparam logic [7:0] CmdMemoryWrite = 8'h2C;

  localparam logic KindCommand = 1'b0;
  localparam logic KindData    = 1'b1;

  localparam logic [1:0] PhaseStartLow = 2'd1;
  localparam logic [1:0] PhaseEndLow   = 2'd3;

  typedef enum logic [1:0] {
    ModeIdle  = 2'd0,
    ModeCols  = 2'd1,
    ModeRows  = 2'd2,
    ModeWrite = 2'd3
  } mode_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] column;
    logic [15:0] row;
    logic [15:0] pixel;
    logic        off_panel;
  } out_item_t;

endpackage

>>> rtl/dwpw_in_stage.sv
module dwpw_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dwpw_pkg::in_item_t in_data_i,
  input  logic               advance_i,
  output logic               item_valid_o,
  output dwpw_pkg::in_item_t item_o
);
  import dwpw_pkg::*;

  logic     valid_q;
  in_item_t item_q;
  logic     load;

  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

>>> rtl/dwpw_core.sv
module dwpw_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  dwpw_pkg::in_item_t  item_i,
  output logic                result_valid_o,
  output dwpw_pkg::out_item_t result_o
);
  import dwpw_pkg::*;

  mode_e       mode_q, mode_d;
  logic [1:0]  phase_q, phase_d;
  logic [15:0] col_start_q, col_start_d;
  logic [15:0] col_end_q, col_end_d;
  logic [15:0] row_start_q, row_start_d;
  logic [15:0] row_end_q, row_end_d;
  logic [15:0] cursor_col_q, cursor_col_d;
  logic [15:0] cursor_row_q, cursor_row_d;
  logic [7:0]  high_byte_q, high_byte_d;
  logic        have_high_q, have_high_d;
  logic [15:0] word;
  logic        is_cmd;
  logic        is_addr_mode;

  assign word         = {high_byte_q, item_i.value};
  assign is_cmd       = (item_i.kind == KindCommand);
  assign is_addr_mode = (mode_q == ModeCols) || (mode_q == ModeRows);

  always_comb begin
    mode_d = mode_q;
    if (fire_i) begin
      if (is_cmd) begin
        unique case (item_i.value)
          CmdColumnAddr:  mode_d = ModeCols;
          CmdPageAddr:    mode_d = ModeRows;
          CmdMemoryWrite: mode_d = ModeWrite;
          default:        mode_d = ModeIdle;
        endcase
      end else if (is_addr_mode && (phase_q == PhaseEndLow)) begin
        mode_d = ModeIdle;
      end
    end
  end

  always_comb begin
    phase_d        = phase_q;
    col_start_d    = col_start_q;
    col_end_d      = col_end_q;
    row_start_d    = row_start_q;
    row_end_d      = row_end_q;
    cursor_col_d   = cursor_col_q;
    cursor_row_d   = cursor_row_q;
    high_byte_d    = high_byte_q;
    have_high_d    = have_high_q;
    result_valid_o = 1'b0;
    if (fire_i) begin
      if (is_cmd) begin
        have_high_d = 1'b0;
        phase_d     = 2'd0;
        if (item_i.value == CmdMemoryWrite) begin
          cursor_col_d = col_start_q;
          cursor_row_d = row_start_q;
        end
      end else begin
        unique case (mode_q)
          ModeCols, ModeRows: begin
            phase_d = phase_q + 2'd1;
            if (phase_q == PhaseStartLow) begin
              if (mode_q == ModeCols) begin
                col_start_d = word;
              end else begin
                row_start_d = word;
              end
            end else if (phase_q == PhaseEndLow) begin
              if (mode_q == ModeCols) begin
                col_end_d = word;
              end else begin
                row_end_d = word;
              end
            end else begin
              high_byte_d = item_i.value;
            end
          end
          ModeWrite: begin
            if (!have_high_q) begin
              high_byte_d = item_i.value;
              have_high_d = 1'b1;
            end else begin
              have_high_d    = 1'b0;
              result_valid_o = 1'b1;
              if (cursor_col_q >= col_end_q) begin
                cursor_col_d = col_start_q;
                if (cursor_row_q >= row_end_q) begin
                  cursor_row_d = row_start_q;
                end else begin
                  cursor_row_d = cursor_row_q + 16'd1;
                end
              end else begin
                cursor_col_d = cursor_col_q + 16'd1;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign result_o.column    = cursor_col_q;
  assign result_o.row       = cursor_row_q;
  assign result_o.pixel     = word;
  assign result_o.off_panel = (cursor_col_q >= PanelWidth) || (cursor_row_q >= PanelHeight);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeIdle;
      phase_q      <= 2'd0;
      col_start_q  <= 16'd0;
      col_end_q    <= ColEndReset;
      row_start_q  <= 16'd0;
      row_end_q    <= RowEndReset;
      cursor_col_q <= 16'd0;
      cursor_row_q <= 16'd0;
      high_byte_q  <= 8'd0;
      have_high_q  <= 1'b0;
    end else begin
      mode_q       <= mode_d;
      phase_q      <= phase_d;
      col_start_q  <= col_start_d;
      col_end_q    <= col_end_d;
      row_start_q  <= row_start_d;
      row_end_q    <= row_end_d;
      cursor_col_q <= cursor_col_d;
      cursor_row_q <= cursor_row_d;
      high_byte_q  <= high_byte_d;
      have_high_q  <= have_high_d;
    end
  end

endmodule

>>> rtl/dwpw_out_stage.sv
module dwpw_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                result_valid_i,
  input  dwpw_pkg::out_item_t result_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dwpw_pkg::out_item_t out_data_o
);
  import dwpw_pkg::*;

  logic      valid_q;
  out_item_t data_q;
  logic      load;

  assign free_o = !valid_q || out_ready_i;
  assign load   = result_valid_i && free_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

>>> rtl/display_window_pixel_writer.sv
// Channel | Direction | Handshake               | Payload
// input   | in        | in_valid_i, in_ready_o   | in_data_i (kind, value)
// output  | out       | out_valid_o, out_ready_i | out_data_o (column, row, pixel, off_panel)
//
// One byte is taken per cycle unless a stalled output holds the input register. A byte that
// completes a pixel loads it into the output register as the byte leaves the input register.
// Reset clears the window to the full panel and leaves the block idle.
// A stalled output stops the input register only once both registers are full.
module display_window_pixel_writer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dwpw_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dwpw_pkg::out_item_t out_data_o
);
  import dwpw_pkg::*;

  logic      item_valid;
  in_item_t  item;
  logic      advance;
  logic      free;
  logic      result_valid;
  out_item_t result;

  assign advance = item_valid && free;

  dwpw_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  dwpw_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (advance),
    .item_i         (item),
    .result_valid_o (result_valid),
    .result_o       (result)
  );

  dwpw_out_stage u_out_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .result_valid_i (result_valid),
    .result_i       (result),
    .free_o         (free),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_o     (out_data_o)
  );

endmodule

>>> rtl/dwpw_checker.sv
module dwpw_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input dwpw_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input dwpw_pkg::out_item_t out_data_o
);
  import dwpw_pkg::*;

  // An empty output register never holds back the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output register empty");

  // A drained output always frees room for the next byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |-> in_ready_o)
    else $error("input stalled while output drains");

  // The off-panel flag agrees with the reported coordinates.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.off_panel ==
      ((out_data_o.column >= PanelWidth) || (out_data_o.row >= PanelHeight))))
    else $error("off_panel flag inconsistent with coordinates");

  // A stalled result keeps its valid and its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled output transaction changed");

  // A waiting input transaction keeps its valid and its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o) |=> (in_valid_i && $stable(in_data_i)))
    else $error("waiting input transaction changed");

endmodule

bind display_window_pixel_writer dwpw_checker u_dwpw_checker (.*);

>>> tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dwpw_pkg::*;

  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned RandomBytes = 1750;
  localparam int unsigned DrainCycles = 20;
  localparam logic [7:0]  CmdNop      = 8'h00;

  typedef struct {
    in_item_t item;
    bit       settle;
  } queued_byte_t;

  logic      clk_i = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  queued_byte_t outgoing[$];
  out_item_t    expected_pixels[$];
  int unsigned  cycle_count = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  gap_left = 0;
  int unsigned  stall_left = 0;

  mode_e       ctl_mode = ModeIdle;
  logic [1:0]  addr_phase = 2'd0;
  logic [15:0] win_col_first = 16'd0;
  logic [15:0] win_col_last = ColEndReset;
  logic [15:0] win_row_first = 16'd0;
  logic [15:0] win_row_last = RowEndReset;
  logic [15:0] cur_col = 16'd0;
  logic [15:0] cur_row = 16'd0;
  logic [7:0]  held_byte = 8'd0;
  logic        held_valid = 1'b0;

  display_window_pixel_writer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #5 clk_i = ~clk_i;

  function automatic void track_byte(input in_item_t b);
    out_item_t   px;
    logic [15:0] word;
    word = {held_byte, b.value};
    if (b.kind == KindCommand) begin
      held_valid = 1'b0;
      addr_phase = 2'd0;
      case (b.value)
        CmdColumnAddr: ctl_mode = ModeCols;
        CmdPageAddr: ctl_mode = ModeRows;
        CmdMemoryWrite: begin
          ctl_mode = ModeWrite;
          cur_col  = win_col_first;
          cur_row  = win_row_first;
        end
        default: ctl_mode = ModeIdle;
      endcase
    end else if (ctl_mode == ModeCols || ctl_mode == ModeRows) begin
      case (addr_phase)
        PhaseStartLow: begin
          if (ctl_mode == ModeCols) win_col_first = word;
          else win_row_first = word;
        end
        PhaseEndLow: begin
          if (ctl_mode == ModeCols) win_col_last = word;
          else win_row_last = word;
          ctl_mode = ModeIdle;
        end
        default: held_byte = b.value;
      endcase
      addr_phase = addr_phase + 2'd1;
    end else if (ctl_mode == ModeWrite) begin
      if (!held_valid) begin
        held_byte  = b.value;
        held_valid = 1'b1;
      end else begin
        held_valid   = 1'b0;
        px.column    = cur_col;
        px.row       = cur_row;
        px.pixel     = word;
        px.off_panel = (cur_col >= PanelWidth) || (cur_row >= PanelHeight);
        expected_pixels.push_back(px);
        if (cur_col >= win_col_last) begin
          cur_col = win_col_first;
          if (cur_row >= win_row_last) cur_row = win_row_first;
          else cur_row = cur_row + 16'd1;
        end else begin
          cur_col = cur_col + 16'd1;
        end
      end
    end
  endfunction

  function automatic int unsigned pick_pause(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_span(input logic [15:0] extent);
    logic [15:0] lo;
    logic [15:0] hi;
    int unsigned r;
    r  = $urandom_range(0, 99);
    lo = 16'($urandom_range(0, extent + 8));
    hi = lo + 16'($urandom_range(0, 5));
    if (r < 8) begin
      hi = lo - 16'($urandom_range(1, 4));
    end else if (r < 14) begin
      lo = 16'($urandom);
      hi = 16'($urandom);
    end else if (r < 17) begin
      lo = 16'd0;
      hi = extent - 16'd1;
    end
    return {lo, hi};
  endfunction

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (want !== got) begin
      $display("t=%0t: %s expected %h, got %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic queue_byte(input logic kind, input logic [7:0] value, input bit settle);
    queued_byte_t q;
    q.item.kind  = kind;
    q.item.value = value;
    q.settle     = settle;
    outgoing.push_back(q);
  endtask

  always @(posedge clk_i) begin : drive_bytes
    bit taken;
    taken = in_valid && in_ready;
    if (taken) track_byte(in_data);
    if (rst_n && !(in_valid && !taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (outgoing.size() != 0 &&
                   !(outgoing[0].settle && expected_pixels.size() != 0)) begin
        in_data  <= outgoing[0].item;
        in_valid <= 1'b1;
        void'(outgoing.pop_front());
        gap_left = pick_pause(cycle_count % 3000 < 700);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : watch_pixels
    out_item_t want;
    if (out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $display("t=%0t: expected no transaction, got pixel %h at column %h row %h",
                 $time, out_data.pixel, out_data.column, out_data.row);
        mismatch_count++;
      end else begin
        want = expected_pixels.pop_front();
        compare_field("column", want.column, out_data.column);
        compare_field("row", want.row, out_data.row);
        compare_field("pixel", want.pixel, out_data.pixel);
        compare_field("off_panel", {15'd0, want.off_panel}, {15'd0, out_data.off_panel});
      end
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      stall_left = pick_pause((cycle_count + 1500) % 3000 < 700);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [8:0]  opening [0:22];
    logic [31:0] span;
    int unsigned counted;
    int unsigned r;
    int unsigned n;
    int unsigned cut;
    bit          first_write;

    // Data while idle, a plain write, a half pixel dropped by a command, then a
    // window whose start lies beyond its end and off the panel, with the row
    // command cut short after its start value.
    opening = '{
      {KindData, 8'hFF},
      {KindCommand, CmdMemoryWrite},
      {KindData, 8'h00}, {KindData, 8'h00}, {KindData, 8'hFF}, {KindData, 8'hFF},
      {KindData, 8'h12}, {KindCommand, CmdNop}, {KindData, 8'h34},
      {KindCommand, CmdColumnAddr},
      {KindData, 8'hFF}, {KindData, 8'hFF}, {KindData, 8'h00}, {KindData, 8'h01},
      {KindData, 8'h77},
      {KindCommand, CmdPageAddr}, {KindData, 8'h01}, {KindData, 8'h40},
      {KindCommand, CmdMemoryWrite},
      {KindData, 8'hAA}, {KindData, 8'h55}, {KindData, 8'h0F}, {KindData, 8'hF0}
    };
    foreach (opening[k]) queue_byte(opening[k][8], opening[k][7:0], 1'b0);

    counted     = 0;
    first_write = 1'b1;
    while (counted < RandomBytes) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        span = pick_span(r < 25 ? PanelWidth : PanelHeight);
        queue_byte(KindCommand, r < 25 ? CmdColumnAddr : CmdPageAddr, 1'b0);
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 4;
        for (int k = 0; k < cut; k++) queue_byte(KindData, span[31 - 8 * k -: 8], 1'b0);
        if (cut == 4 && $urandom_range(0, 9) == 0) queue_byte(KindData, 8'($urandom), 1'b0);
        counted += cut + 1;
      end else if (r < 80) begin
        queue_byte(KindCommand, CmdMemoryWrite, first_write || $urandom_range(0, 49) == 0);
        first_write = 1'b0;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 120) : $urandom_range(1, 24);
        for (int k = 0; k < 2 * n; k++) queue_byte(KindData, 8'($urandom), 1'b0);
        if ($urandom_range(0, 6) == 0) queue_byte(KindData, 8'($urandom), 1'b0);
        counted += 2 * n + 1;
      end else if (r < 90) begin
        queue_byte(KindCommand, 8'($urandom), 1'b0);
        n = $urandom_range(0, 3);
        for (int k = 0; k < n; k++) queue_byte(KindData, 8'($urandom), 1'b0);
        counted++;
      end else begin
        n = $urandom_range(1, 5);
        for (int k = 0; k < n; k++) queue_byte(1'($urandom), 8'($urandom), 1'b0);
      end
    end

    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;

    do @(posedge clk_i);
    while (outgoing.size() != 0 || in_valid || expected_pixels.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/dwpw_pkg.sv
rtl/dwpw_in_stage.sv
rtl/dwpw_core.sv
rtl/dwpw_out_stage.sv
rtl/display_window_pixel_writer.sv
rtl/dwpw_checker.sv
tb/tb.sv
